### rtl/sha512_message_digest_unit_macros.svh
// assertion macros for the sha-512 digest unit
// used by sha512_message_digest_unit.sv, no other dependencies
`ifndef SHA512_MESSAGE_DIGEST_UNIT_MACROS_SVH
`define SHA512_MESSAGE_DIGEST_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SMD_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("smd check failed");

// next-cycle implication, disabled during reset
`define SMD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("smd check failed");

`endif

### rtl/smd_pkg.sv
// shared types, constants and round functions of the sha-512 digest unit
// no dependencies
package smd_pkg;

    localparam int WordW  = 64;
    localparam int Rounds = 80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_PRIME,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    function automatic logic [63:0] init_hash(input logic [2:0] i);
        logic [63:0] v;
        case (i)
            3'd0: v = 64'h6a09e667f3bcc908;
            3'd1: v = 64'hbb67ae8584caa73b;
            3'd2: v = 64'h3c6ef372fe94f82b;
            3'd3: v = 64'ha54ff53a5f1d36f1;
            3'd4: v = 64'h510e527fade682d1;
            3'd5: v = 64'h9b05688c2b3e6c1f;
            3'd6: v = 64'h1f83d9abfb41bd6b;
            default: v = 64'h5be0cd19137e2179;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] big_sig0(input logic [63:0] x);
        return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] big_sig1(input logic [63:0] x);
        return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic logic [63:0] sm_sig0(input logic [63:0] x);
        return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] sm_sig1(input logic [63:0] x);
        return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

endpackage

### rtl/sha512_message_digest_unit.sv
// SHA-512 digest unit: takes big-endian 64-bit message words over a stream input, pads the
// message, compresses each 1024-bit block in 80 rounds and streams out H0..H7. Each message
// word is written into a 16-entry block memory; when the block fills, a priming step starts
// the memory read, the rounds run one per cycle, and a final step adds into the hash state.
// After the last word the unit writes the padding words one per cycle (compressing an extra
// block if the padding spills over), then gives eight digest items, one per cycle while the
// output is taken. Input is held off meanwhile.
// Depends on smd_pkg and sha512_message_digest_unit_macros.svh.
`include "sha512_message_digest_unit_macros.svh"

module sha512_message_digest_unit
    import smd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] msg_word, [67:64] byte_count, zero fill
    input  logic        s_tlast,   // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] digest_word, [66:64] word_index, zero fill
    output logic        m_tlast    // last_digest_word
);

    state_t      state_reg, state_next;
    logic [63:0] hash_reg [8];
    logic [63:0] work_reg [8];
    logic [63:0] win_reg [16];
    logic [63:0] blk_mem [16];
    logic [63:0] rd_reg;
    logic [63:0] bitlen_reg;
    logic [3:0]  slot_reg;
    logic [6:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic        pad_reg, one_reg, lenph_reg, done_reg;

    logic        s_hs, m_hs, push;
    logic [63:0] push_word;
    logic [3:0]  cnt;
    logic [5:0]  sh;
    logic [63:0] first_word;
    logic [3:0]  rd_addr;
    logic [63:0] w_t, t1, t2;

    assign s_hs = s_tvalid && s_tready;
    assign m_hs = m_tvalid && m_tready;

    // saturate byte count and build the padded last word
    assign cnt        = s_tdata[67] ? 4'd8 : s_tdata[67:64];
    assign sh         = {cnt[2:0], 3'b000};
    assign first_word = (s_tdata[63:0] & ~(64'hffffffffffffffff >> sh))
                      | (64'h8000000000000000 >> sh);

    // word written into the block memory this cycle
    always_comb begin
        push      = 1'b0;
        push_word = 64'h0;
        if (state_reg == ST_IDLE && s_hs) begin
            push      = 1'b1;
            push_word = (s_tlast && !s_tdata[67]) ? first_word : s_tdata[63:0];
        end else if (state_reg == ST_PAD) begin
            push = 1'b1;
            if (one_reg)
                push_word = 64'h8000000000000000;
            else if (lenph_reg)
                push_word = bitlen_reg;
            else
                push_word = 64'h0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_hs) begin
                    if (slot_reg == 4'd15)
                        state_next = ST_PRIME;
                    else if (s_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                if (slot_reg == 4'd15)
                    state_next = ST_PRIME;
            end
            ST_PRIME: state_next = ST_ROUND;
            ST_ROUND: begin
                if (rnd_reg == 7'(Rounds - 1))
                    state_next = ST_FINAL;
            end
            ST_FINAL: begin
                if (done_reg)
                    state_next = ST_OUT;
                else if (pad_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT: begin
                if (m_hs && idx_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = {5'b0, idx_reg, hash_reg[idx_reg]};
        m_tlast  = (idx_reg == 3'd7);
    end

    // block memory, synchronous write and registered read
    assign rd_addr = (state_reg == ST_PRIME) ? 4'd0 : 4'(rnd_reg + 7'd1);
    always_ff @(posedge aclk) begin
        if (push)
            blk_mem[slot_reg] <= push_word;
        rd_reg <= blk_mem[rd_addr];
    end

    // round datapath
    always_comb begin
        if (rnd_reg < 7'd16)
            w_t = rd_reg;
        else
            w_t = win_reg[0] + sm_sig0(win_reg[1]) + win_reg[9] + sm_sig1(win_reg[14]);
        t1 = work_reg[7] + big_sig1(work_reg[4])
           + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
           + round_k(rnd_reg) + w_t;
        t2 = big_sig0(work_reg[0])
           + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));
    end

    // schedule window and working registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PRIME) begin
            for (int i = 0; i < 8; i++)
                work_reg[i] <= hash_reg[i];
        end else if (state_reg == ST_ROUND) begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[15] <= w_t;
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
        end
    end

    // control and hash state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            bitlen_reg <= 64'h0;
            slot_reg   <= 4'd0;
            rnd_reg    <= 7'd0;
            idx_reg    <= 3'd0;
            pad_reg    <= 1'b0;
            one_reg    <= 1'b0;
            lenph_reg  <= 1'b0;
            done_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= init_hash(3'(i));
        end else begin
            state_reg <= state_next;
            if (push)
                slot_reg <= slot_reg + 4'd1;
            // length count and padding flags on input
            if (state_reg == ST_IDLE && s_hs) begin
                if (s_tlast) begin
                    bitlen_reg <= bitlen_reg + {57'b0, cnt, 3'b000};
                    pad_reg    <= 1'b1;
                    one_reg    <= s_tdata[67];
                end else begin
                    bitlen_reg <= bitlen_reg + 64'd64;
                end
            end
            // padding sequence
            if (state_reg == ST_PAD) begin
                if (one_reg)
                    one_reg <= 1'b0;
                else if (lenph_reg) begin
                    lenph_reg <= 1'b0;
                    done_reg  <= 1'b1;
                end else if (slot_reg == 4'd14)
                    lenph_reg <= 1'b1;
            end
            // round counter
            if (state_reg == ST_ROUND)
                rnd_reg <= (rnd_reg == 7'(Rounds - 1)) ? 7'd0 : rnd_reg + 7'd1;
            // fold working registers into the hash
            if (state_reg == ST_FINAL) begin
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + work_reg[i];
            end
            // digest output and re-initialisation
            if (state_reg == ST_OUT && m_hs) begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7) begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= init_hash(3'(i));
                    bitlen_reg <= 64'h0;
                    pad_reg    <= 1'b0;
                    done_reg   <= 1'b0;
                end
            end
        end
    end

    // checks
    `SMD_ASSERT_NOW(a_no_overlap, aclk, aresetn, s_tready, !m_tvalid)
    `SMD_ASSERT_NEXT(a_round_end, aclk, aresetn,
        state_reg == ST_ROUND && rnd_reg == 7'(Rounds - 1), state_reg == ST_FINAL)
    `SMD_ASSERT_NEXT(a_out_end, aclk, aresetn, m_hs && m_tlast, state_reg == ST_IDLE)
    `SMD_ASSERT_NOW(a_out_slot, aclk, aresetn, m_tvalid, slot_reg == 4'd0 && rnd_reg == 7'd0)

endmodule

### dv/sha512_message_digest_unit_tb.sv
// self-checking testbench for the sha-512 message digest unit
// depends on smd_pkg and sha512_message_digest_unit (rtl)
module sha512_message_digest_unit_tb;
    import smd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_item_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;

    sha512_message_digest_unit u_top (.*);

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    localparam logic [63:0] KT [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    localparam int CycleLimit = 2000000;

    // predictor state
    logic [63:0] hash_q [8];
    logic [63:0] blk_q [16];
    logic [63:0] len_bits;
    int          fill_slot;

    digest_item_t digest_fifo [$];
    int  mismatches = 0;
    int  digests_seen = 0;
    int  words_sent;
    int  messages_sent;
    int  cycles = 0;

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // 80 rounds over the filled block, folded into the hash state
    task automatic compress_block_model();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] t1, t2, s0, s1;
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                w[t] = blk_q[t];
            end else begin
                s0 = ror(w[t-15], 1) ^ ror(w[t-15], 8) ^ (w[t-15] >> 7);
                s1 = ror(w[t-2], 19) ^ ror(w[t-2], 61) ^ (w[t-2] >> 6);
                w[t] = w[t-16] + s0 + w[t-7] + s1;
            end
        end
        for (int i = 0; i < 8; i++) v[i] = hash_q[i];
        for (int t = 0; t < 80; t++) begin
            t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KT[t] + w[t];
            t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_q[i] += v[i];
    endtask

    task automatic push_block_word(input logic [63:0] w);
        blk_q[fill_slot] = w;
        fill_slot++;
        if (fill_slot == 16) begin
            compress_block_model();
            fill_slot = 0;
        end
    endtask

    // predict digests for one accepted message word
    task automatic predict_word(input logic [63:0] w, input logic [3:0] cnt, input logic lst);
        int n;
        logic [63:0] keep;
        digest_item_t d;
        if (!lst) begin
            len_bits += 64;
            push_block_word(w);
            return;
        end
        n = (cnt > 8) ? 8 : cnt;
        len_bits += 64'(n * 8);
        if (n == 8) begin
            push_block_word(w);
            push_block_word(64'h8000000000000000);
        end else begin
            keep = (n == 0) ? 64'h0 : ~64'h0 << (64 - 8 * n);
            push_block_word((w & keep) | (64'h80 << (56 - 8 * n)));
        end
        while (fill_slot != 14) push_block_word(64'h0);
        push_block_word(64'h0);
        push_block_word(len_bits);
        for (int i = 0; i < 8; i++) begin
            d.word = hash_q[i];
            d.idx  = 3'(i);
            d.last = (i == 7);
            digest_fifo.push_back(d);
            hash_q[i] = IV[i];
        end
        len_bits  = 0;
        fill_slot = 0;
    endtask

    // clock and cycle limit
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("sha512_message_digest_unit verification failed");
            $finish;
        end
    end

    // receiver stall pattern: periodic windows plus random stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if ((cycles / 64) % 4 == 3) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 9) < 6) && ((cycles % 37) > 3);
        end
    end

    // check each digest item against the oldest expectation
    always @(posedge aclk) begin
        digest_item_t exp_d;
        if (aresetn && m_tvalid && m_tready) begin
            digests_seen++;
            if (digest_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest item %h idx %0d", m_tdata[63:0], m_tdata[66:64]);
            end else begin
                exp_d = digest_fifo.pop_front();
                if (m_tdata[63:0] !== exp_d.word || m_tdata[66:64] !== exp_d.idx
                    || m_tdata[71:67] !== 5'h0 || m_tlast !== exp_d.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 exp_d.word, exp_d.idx, exp_d.last,
                                 m_tdata[63:0], m_tdata[66:64], m_tlast);
                end
            end
        end
    end

    // burst state for the sender
    int burst_left;
    int gap_left;

    // send one item, idling between bursts
    task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic lst);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        while (gap_left > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            gap_left--;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, cnt, w};
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_word(w, cnt, lst);
        words_sent++;
        if (lst) messages_sent++;
        burst_left--;
        if (burst_left == 0 || $urandom_range(0, 7) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic send_message(input int nwords, input logic [3:0] last_cnt);
        for (int i = 0; i < nwords; i++)
            send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
        send_word({$urandom, $urandom}, last_cnt, 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (digest_fifo.size() != 0) @(posedge aclk);
    endtask

    // known text "abc" plus empty message and all-ones words
    task automatic test_directed();
        send_word(64'h6162630000000000, 4'd3, 1'b1);
        send_word(64'h0, 4'd0, 1'b1);
        send_word(64'hffffffffffffffff, 4'd8, 1'b1);
        send_word(64'hffffffffffffffff, 4'd15, 1'b1);
        send_word(64'h0, 4'd9, 1'b0);
        send_word(64'hffffffffffffffff, 4'd7, 1'b1);
        for (int i = 0; i < 13; i++) send_word(64'ha5a5a5a5a5a5a5a5 ^ i, 4'd8, 1'b0);
        send_word(64'h0123456789abcdef, 4'd8, 1'b1);
        send_word(64'hfedcba9876543210, 4'd1, 1'b1);
        send_word(64'h5555555555555555, 4'd5, 1'b1);
    endtask

    // messages whose padding lands across a block boundary
    task automatic test_block_boundaries();
        for (int n = 13; n <= 16; n++) send_message(n, 4'($urandom_range(0, 8)));
    endtask

    // random messages, mostly short, some longer than a block
    task automatic test_random_messages();
        int n;
        while (words_sent < 520) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 12);
            send_message(n, ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                        : 4'($urandom_range(0, 8)));
            if (messages_sent % 17 == 0) wait_drained();
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        words_sent = 0;
        messages_sent = 0;
        burst_left = 0;
        gap_left   = 0;
        len_bits   = 0;
        fill_slot  = 0;
        for (int i = 0; i < 8; i++) hash_q[i] = IV[i];
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        wait_drained();
        test_block_boundaries();
        test_random_messages();
        wait_drained();
        repeat (200) @(posedge aclk);

        $display("sent %0d words in %0d messages, checked %0d digest items",
                 words_sent, messages_sent, digests_seen);
        if (mismatches == 0 && digest_fifo.size() == 0) begin
            $display("sha512_message_digest_unit verification clean");
        end else begin
            $display("%0d mismatches, %0d digest items missing", mismatches, digest_fifo.size());
            $display("sha512_message_digest_unit verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/smd_pkg.sv
rtl/sha512_message_digest_unit.sv
dv/sha512_message_digest_unit_tb.sv
